// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that prop holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("%m: assertion failed");

// check that prop never holds at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
	else $error("%m: forbidden condition seen");

`endif

// ===== hdl/aek_pkg.sv =====
package aek_pkg;

	typedef enum logic [1:0] {
		MODE_128 = 2'd0,
		MODE_192 = 2'd1,
		MODE_256 = 2'd2
	} key_mode_t;

	typedef enum logic {
		ST_LOAD,
		ST_EXPAND
	} kx_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [31:0] sbox_word(input logic [31:0] v);
		sbox_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rot_word(input logic [31:0] v);
		rot_word = {v[23:0], v[31:24]};
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ===== hdl/aek_ram.sv =====
module aek_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/aes_key_expansion.sv =====
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------------
// key in    | in_valid  | in_stall  | key_word
// schedule  | out_valid | out_stall | schedule_word, word_index, last_word
// config    | cfg_write | -         | key_length_mode
//
// Each accepted key word, the Nk-th included, is echoed on the next cycle.
// The Nk-th word starts the expansion: one schedule word per cycle while the output
// is not stalled, 40, 46 or 52 more words in all.
// Reset clears control state only; the window RAM needs no clearing pass.
// A stalled output register holds the expansion in place.
`include "assert_macros.svh"

module aes_key_expansion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  key_length_mode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] key_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] schedule_word,
	output logic [5:0]  word_index,
	output logic        last_word
);

	import aek_pkg::*;

	kx_state_t   state_q, state_d;
	logic [1:0]  mode_q;
	logic [2:0]  wl_q;
	logic [2:0]  pos_q, pos_d, pos_next;
	logic [5:0]  idx_q;
	logic [7:0]  rcon_q;
	logic [31:0] prev_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [5:0]  out_index_q;
	logic        out_last_q;

	logic [3:0]  nk;
	logic [2:0]  nk_m1;
	logic [5:0]  total_m1;
	logic        out_free, in_acc, is_final, step, last;
	logic [31:0] temp, new_word;

	logic        ram_we;
	logic [2:0]  ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	aek_ram #(
		.WIDTH(32),
		.DEPTH(8)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		unique case (mode_q)
			MODE_128: begin
				nk       = 4'd4;
				total_m1 = 6'd43;
			end
			MODE_192: begin
				nk       = 4'd6;
				total_m1 = 6'd51;
			end
			default: begin
				nk       = 4'd8;
				total_m1 = 6'd59;
			end
		endcase
	end

	assign nk_m1    = 3'(nk - 4'd1);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == ST_LOAD && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign is_final = {1'b0, wl_q} >= (nk - 4'd1);
	assign step     = (state_q == ST_EXPAND) && out_free;
	assign last     = idx_q >= total_m1;
	assign pos_next = (pos_q == nk_m1) ? 3'd0 : pos_q + 3'd1;

	always_comb begin
		temp = prev_q;
		if (pos_q == 3'd0) begin
			temp = sbox_word(rot_word(prev_q)) ^ {rcon_q, 24'h000000};
		end else if (nk == 4'd8 && pos_q == 3'd4) begin
			temp = sbox_word(prev_q);
		end
	end

	assign new_word = ram_rdata ^ temp;

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_word;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					ram_we    = 1'b1;
					ram_wdata = key_word;
					if (is_final) begin
						ram_waddr = nk_m1;
						state_d   = ST_EXPAND;
					end else begin
						ram_waddr = wl_q;
					end
				end
			end
			ST_EXPAND: begin
				if (step) begin
					ram_we = 1'b1;
					pos_d  = last ? 3'd0 : pos_next;
					if (last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// read ahead: addressed by pos_d, so the registered read data is the entry for pos_q
	assign ram_raddr = pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			mode_q      <= MODE_128;
			wl_q        <= 3'd0;
			pos_q       <= 3'd0;
			idx_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			if (cfg_write) begin
				mode_q <= key_length_mode;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
				if (is_final) begin
					wl_q  <= 3'd0;
					idx_q <= {2'b00, nk};
				end else begin
					wl_q <= wl_q + 3'd1;
				end
			end else if (step) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 6'd1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_word_q  <= key_word;
			out_index_q <= is_final ? {3'b000, nk_m1} : {3'b000, wl_q};
			out_last_q  <= 1'b0;
			prev_q      <= key_word;
			rcon_q      <= 8'h01;
		end else if (step) begin
			out_word_q  <= new_word;
			out_index_q <= idx_q;
			out_last_q  <= last;
			prev_q      <= new_word;
			if (pos_q == 3'd0) begin
				rcon_q <= gf_double(rcon_q);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign schedule_word = out_word_q;
	assign word_index    = out_index_q;
	assign last_word     = out_last_q;

	`ASSERT_NEVER(a_no_take_in_expand, clk, arst_n, (state_q == ST_EXPAND) && in_acc)
	`ASSERT_HOLDS(a_count_clear_in_expand, clk, arst_n, (state_q == ST_EXPAND) |-> (wl_q == 3'd0))
	`ASSERT_HOLDS(a_last_ends_expand, clk, arst_n, (out_valid_q && out_last_q) |-> (state_q == ST_LOAD))
	`ASSERT_HOLDS(a_hold_on_stall, clk, arst_n, (state_q == ST_EXPAND && out_valid_q && out_stall) |=> $stable(idx_q))

endmodule

// ===== test/aes_key_schedule_checker.sv =====
`timescale 1ns / 100ps

module aes_key_schedule_checker
	import aek_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  key_length_mode,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] key_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] schedule_word,
	input  logic [5:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [5:0]  index;
		logic        last;
	} sched_entry_t;

	sched_entry_t schedule_q[$];
	logic [7:0]   sbox_tab[256];
	logic [31:0]  window_q[8];
	logic [3:0]   loaded_q;
	logic [1:0]   mode_q;

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p ^= x;
			x = xtime(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] affine_of_inverse(input logic [7:0] b);
		logic [7:0] inv;
		inv = 8'h00;
		for (int y = 1; y < 256; y++)
			if (gf_mul(b, 8'(y)) == 8'h01)
				inv = 8'(y);
		return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
			{inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [31:0] sub_bytes_word(input logic [31:0] v);
		return {sbox_tab[v[31:24]], sbox_tab[v[23:16]], sbox_tab[v[15:8]], sbox_tab[v[7:0]]};
	endfunction

	function automatic int key_words(input logic [1:0] m);
		case (m)
			MODE_128: return 4;
			MODE_192: return 6;
			default: return 8;
		endcase
	endfunction

	task automatic push_expected(input logic [31:0] word, input int idx, input logic last);
		sched_entry_t e;
		e.word = word;
		e.index = 6'(idx);
		e.last = last;
		schedule_q.push_back(e);
	endtask

	task automatic expand_key_word(input logic [31:0] kw);
		int          nk;
		int          total;
		logic [31:0] w[60];
		logic [31:0] t;
		logic [7:0]  rc;
		nk = key_words(mode_q);
		total = 4 * (nk + 7);
		if (int'(loaded_q) < nk - 1) begin
			window_q[loaded_q[2:0]] = kw;
			push_expected(kw, int'(loaded_q), 1'b0);
			loaded_q = loaded_q + 4'd1;
		end else begin
			window_q[nk - 1] = kw;
			for (int i = 0; i < nk; i++)
				w[i] = window_q[i];
			rc = 8'h01;
			for (int i = nk; i < total; i++) begin
				t = w[i - 1];
				if (i % nk == 0) begin
					t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h000000};
					rc = xtime(rc);
				end else if (nk == 8 && i % 8 == 4) begin
					t = sub_bytes_word(t);
				end
				w[i] = w[i - nk] ^ t;
			end
			for (int i = nk - 1; i < total; i++)
				push_expected(w[i], i, i == total - 1);
			for (int i = 0; i < nk; i++)
				window_q[i] = w[total - nk + i];
			loaded_q = 4'd0;
		end
	endtask

	initial begin
		for (int b = 0; b < 256; b++)
			sbox_tab[b] = affine_of_inverse(8'(b));
	end

	always @(posedge clk or negedge arst_n) begin
		sched_entry_t got;
		sched_entry_t exp_e;
		if (!arst_n) begin
			mode_q = MODE_128;
			loaded_q = 4'd0;
			for (int i = 0; i < 8; i++)
				window_q[i] = 32'h0;
			schedule_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_write)
				mode_q = key_length_mode;
			if (in_valid && !in_stall)
				expand_key_word(key_word);
			if (out_valid && !out_stall) begin
				got.word = schedule_word;
				got.index = word_index;
				got.last = last_word;
				if (schedule_q.size() == 0) begin
					$display("%0t: unexpected schedule word %h index %0d last %0d",
						$time, got.word, got.index, got.last);
					fail_count++;
				end else begin
					exp_e = schedule_q.pop_front();
					if (got !== exp_e) begin
						$display("%0t: schedule mismatch: expected %h index %0d last %0d,",
							$time, exp_e.word, exp_e.index, exp_e.last);
						$display("%0t:   actual %h index %0d last %0d",
							$time, got.word, got.index, got.last);
						fail_count++;
					end
				end
			end
			pending = schedule_q.size();
		end
	end

endmodule

// ===== test/tb_aes_key_expansion.sv =====
`timescale 1ns / 100ps

module tb_aes_key_expansion;
	import aek_pkg::*;

	localparam logic [1:0] MODE_ALIAS_256 = 2'd3;
	localparam int RANDOM_ITEMS = 180;
	localparam int HOLD_AT = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int END_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  key_length_mode;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] key_word;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] schedule_word;
	logic [5:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending;

	int          burst_left = 0;
	int          loaded = 0;
	logic [1:0]  cur_mode = MODE_128;
	bit          long_hold_req = 1'b0;

	aes_key_expansion i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.key_length_mode (key_length_mode),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.key_word        (key_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.schedule_word   (schedule_word),
		.word_index      (word_index),
		.last_word       (last_word)
	);

	aes_key_schedule_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.key_length_mode (key_length_mode),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.key_word        (key_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.schedule_word   (schedule_word),
		.word_index      (word_index),
		.last_word       (last_word),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int key_words(input logic [1:0] m);
		case (m)
			MODE_128: return 4;
			MODE_192: return 6;
			default: return 8;
		endcase
	endfunction

	task automatic offer_key_word(input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		key_word <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		loaded = (loaded >= key_words(cur_mode) - 1) ? 0 : loaded + 1;
	endtask

	task automatic drain_schedule();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_key_mode(input logic [1:0] mode);
		cfg_write <= 1'b1;
		key_length_mode <= mode;
		cur_mode = mode;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int seg_len;
		int seg_kind;
		out_stall <= 1'b0;
		forever begin
			seg_len = $urandom_range(5, 60);
			seg_kind = $urandom_range(0, 3);
			repeat (seg_len) begin
				@(negedge clk);
				if (long_hold_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					long_hold_req = 1'b0;
				end else begin
					case (seg_kind)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[aes_key_expansion] ERROR");
		$finish;
	end

	initial begin
		int r;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		key_length_mode <= MODE_128;
		in_valid <= 1'b0;
		key_word <= 32'h0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_key_mode(MODE_128);
		offer_key_word(32'h00000000);
		offer_key_word(32'hffffffff);
		offer_key_word(32'h00000000);
		offer_key_word(32'hffffffff);
		drain_schedule();

		write_key_mode(MODE_192);
		offer_key_word(32'h00010203);
		offer_key_word(32'h04050607);
		offer_key_word(32'h08090a0b);
		offer_key_word(32'h0c0d0e0f);
		offer_key_word(32'h10111213);
		offer_key_word(32'h14151617);
		drain_schedule();

		write_key_mode(MODE_ALIAS_256);
		offer_key_word(32'h603deb10);
		offer_key_word(32'h15ca71be);
		offer_key_word(32'h2b73aef0);
		offer_key_word(32'h857d7781);
		offer_key_word(32'h1f352c07);
		offer_key_word(32'h3b6108d7);
		offer_key_word(32'h2d9810a3);
		offer_key_word(32'h0914dff4);
		drain_schedule();

		// shrink the key length part-way through a key
		write_key_mode(MODE_256);
		repeat (5) offer_key_word($urandom());
		drain_schedule();
		write_key_mode(MODE_128);
		offer_key_word($urandom());
		drain_schedule();
		loaded = 0;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT)
				long_hold_req = 1'b1;
			if (!long_hold_req && ((loaded == 0 && $urandom_range(0, 2) == 0) ||
				$urandom_range(0, 19) == 0)) begin
				drain_schedule();
				write_key_mode(2'($urandom_range(0, 3)));
			end
			r = $urandom_range(0, 15);
			offer_key_word(r == 0 ? 32'h00000000 : r == 1 ? 32'hffffffff : $urandom());
		end

		drain_schedule();
		repeat (END_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[aes_key_expansion] OK");
		else
			$display("[aes_key_expansion] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/aek_pkg.sv
hdl/aek_ram.sv
hdl/aes_key_expansion.sv
test/aes_key_schedule_checker.sv
test/tb_aes_key_expansion.sv
